### design/p1tfc_pkg.sv
// Package for the P1 telegram frame checker: character codes, status codes,
// CRC constants and the hex digit decoder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package p1tfc_pkg;

	localparam logic [7:0]  START_CHAR = 8'h2F;
	localparam logic [7:0]  MARK_CHAR  = 8'h21;
	localparam logic [7:0]  LF_CHAR    = 8'h0A;
	localparam logic [15:0] CRC_INIT   = 16'h0000;
	localparam logic [15:0] CRC_POLY   = 16'hA001;
	localparam logic [15:0] MAX_LEN_RESET = 16'd2048;
	localparam logic [2:0]  HEX_DIGITS = 3'd4;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_NO_START   = 2'd1,
		ST_INCOMPLETE = 2'd2,
		ST_MISMATCH   = 2'd3
	} status_t;

	// Characters that are not hex digits decode as zero.
	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [7:0] d;
		d = 8'h00;
		priority if (c >= 8'h30 && c <= 8'h39) begin
			d = c - 8'h30;
		end else if (c >= 8'h41 && c <= 8'h46) begin
			d = c - 8'h41 + 8'd10;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			d = c - 8'h61 + 8'd10;
		end else begin
			d = 8'h00;
		end
		return d[3:0];
	endfunction

endpackage
`default_nettype wire

### design/p1tfc_crc16.sv
// Byte-wide CRC-16/ARC update (reflected polynomial), purely combinational.
// Depends on p1tfc_pkg for the polynomial.
`timescale 1ns / 1ps
`default_nettype none
module p1tfc_crc16
	import p1tfc_pkg::*;
(
	input  wire logic [15:0] crc_in,
	input  wire logic [7:0]  data,
	output logic      [15:0] crc_out
);

	always_comb begin
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		crc_out = c;
	end

endmodule
`default_nettype wire

### design/p1_telegram_frame_checker.sv
// P1 telegram frame checker: input register, one-pass parse and CRC stage,
// output register. Depends on p1tfc_pkg and p1tfc_crc16.
//
// Usage:
//   s_tvalid/s_tready/s_tdata carry one received character per transfer.
//   m_tvalid/m_tready/m_tdata/m_tuser carry one result per transfer; m_tuser
//   holds the status, m_tdata the two checksums and the telegram length.
//   cfg_valid/cfg_ready/cfg_data write the length limit (reset value 2048);
//   cfg_ready is always high, and writes are meant for an idle block.
//   A character is registered in the input register when it is transferred,
//   then processed by the parse stage; a result it causes is registered in
//   the output register and shown on m_tvalid. One character is taken every
//   cycle, limited only by the single output register: while a result waits
//   there and m_tready is low, the stage behind it holds and s_tready falls
//   once that stage is full. Characters that cause no result keep flowing
//   into the parser only as the output register frees up.
//   Reset (arst_n low) clears the parser to waiting for '/', empties both
//   registers and restores the length limit. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module p1_telegram_frame_checker
	import p1tfc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] byte_value
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [47:0] m_tdata,   // [15:0] crc_received, [31:16] crc_calculated,
	                                    // [47:32] telegram_length
	output logic      [1:0]  m_tuser,   // [1:0] status
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data
);

	logic [15:0] max_len_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        advance;
	logic        fire;

	logic        in_tel_q, mark_q;
	logic [15:0] crc_q, crc_mark_q, acc_q, pos_q;
	logic [2:0]  cnt_q;

	logic        out_valid_q;
	status_t     out_status_q;
	logic [15:0] out_rx_q, out_calc_q, out_len_q;

	logic [15:0] crc_base, crc_new;
	logic        in_tel_d, mark_d;
	logic [15:0] crc_d, crc_mark_d, acc_d, pos_d;
	logic [2:0]  cnt_d;
	logic        emit;
	status_t     emit_status;
	logic [15:0] emit_rx, emit_calc, emit_len;
	logic [15:0] limit;
	logic [15:0] rx_full;

	assign cfg_ready = 1'b1;
	assign advance   = !out_valid_q || m_tready;
	assign fire      = valid_s1 && advance;
	assign s_tready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_len_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	assign crc_base = in_tel_q ? crc_q : CRC_INIT;

	p1tfc_crc16 u_crc (
		.crc_in  (crc_base),
		.data    (byte_s1),
		.crc_out (crc_new)
	);

	assign limit = (max_len_q == 16'd0) ? 16'd1 : max_len_q;

	// Missing low digits of the received checksum count as zero.
	always_comb begin
		unique case (cnt_q)
			3'd0:    rx_full = 16'h0000;
			3'd1:    rx_full = {acc_q[3:0], 12'h000};
			3'd2:    rx_full = {acc_q[7:0], 8'h00};
			3'd3:    rx_full = {acc_q[11:0], 4'h0};
			default: rx_full = acc_q;
		endcase
	end

	always_comb begin
		in_tel_d    = in_tel_q;
		mark_d      = mark_q;
		crc_d       = crc_q;
		crc_mark_d  = crc_mark_q;
		acc_d       = acc_q;
		cnt_d       = cnt_q;
		pos_d       = pos_q;
		emit        = 1'b0;
		emit_status = ST_OK;
		emit_rx     = 16'h0000;
		emit_calc   = 16'h0000;
		emit_len    = 16'h0000;
		if (!in_tel_q) begin
			if (byte_s1 != START_CHAR) begin
				emit        = 1'b1;
				emit_status = ST_NO_START;
			end else if (limit == 16'd1) begin
				emit        = 1'b1;
				emit_status = ST_INCOMPLETE;
			end else begin
				in_tel_d   = 1'b1;
				mark_d     = 1'b0;
				crc_d      = crc_new;
				crc_mark_d = 16'h0000;
				acc_d      = 16'h0000;
				cnt_d      = 3'd0;
				pos_d      = 16'd1;
			end
		end else begin
			crc_d = crc_new;
			pos_d = pos_q + 16'd1;
			if (mark_q && byte_s1 == LF_CHAR) begin
				emit        = 1'b1;
				emit_rx     = rx_full;
				emit_calc   = crc_mark_q;
				emit_len    = pos_q;
				emit_status = (rx_full != 16'h0000 && rx_full != crc_mark_q) ?
					ST_MISMATCH : ST_OK;
			end else begin
				if (byte_s1 == MARK_CHAR) begin
					mark_d     = 1'b1;
					crc_mark_d = crc_new;
					acc_d      = 16'h0000;
					cnt_d      = 3'd0;
				end else if (mark_q && cnt_q < HEX_DIGITS) begin
					acc_d = {acc_q[11:0], hex_value(byte_s1)};
					cnt_d = cnt_q + 3'd1;
				end
				if ({1'b0, pos_q} + 17'd1 >= {1'b0, limit}) begin
					emit        = 1'b1;
					emit_status = ST_INCOMPLETE;
				end
			end
			if (emit) begin
				in_tel_d   = 1'b0;
				mark_d     = 1'b0;
				crc_d      = CRC_INIT;
				crc_mark_d = 16'h0000;
				acc_d      = 16'h0000;
				cnt_d      = 3'd0;
				pos_d      = 16'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_tel_q   <= 1'b0;
			mark_q     <= 1'b0;
			crc_q      <= CRC_INIT;
			crc_mark_q <= 16'h0000;
			acc_q      <= 16'h0000;
			cnt_q      <= 3'd0;
			pos_q      <= 16'd0;
		end else if (fire) begin
			in_tel_q   <= in_tel_d;
			mark_q     <= mark_d;
			crc_q      <= crc_d;
			crc_mark_q <= crc_mark_d;
			acc_q      <= acc_d;
			cnt_q      <= cnt_d;
			pos_q      <= pos_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			out_status_q <= emit_status;
			out_rx_q     <= emit_rx;
			out_calc_q   <= emit_calc;
			out_len_q    <= emit_len;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {out_len_q, out_calc_q, out_rx_q};

	// Error results other than a checksum mismatch carry no checksum or length.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (out_status_q == ST_NO_START || out_status_q == ST_INCOMPLETE)
		|-> (m_tdata == 48'h0))
		else $error("error result carries nonzero fields");

	// The digit count never runs past four.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= HEX_DIGITS)
		else $error("hex digit count out of range");

	// Outside a telegram no mark is pending and no bytes are counted.
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!in_tel_q |-> (!mark_q && pos_q == 16'd0))
		else $error("parser state not cleared outside a telegram");

	// An empty output register never stalls the parser stage.
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> s_tready)
		else $error("input stalled with empty output register");

endmodule
`default_nettype wire
